// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HEES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HEES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hees_pkg.sv =====
// Types, constants and effect tables of the haptic effect envelope sequencer.
package hees_pkg;

  localparam int TIMER_BITS = 24;
  localparam int TRIG_W     = 8;
  localparam int LVL_W      = 8;
  localparam int EFF_W      = 3;
  localparam int RATE_W     = 20;
  localparam int DUR_W      = 14;
  localparam int STEP_W     = 3;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;
  localparam int MS_W       = 10;
  localparam int PROD_W     = RATE_W + DUR_W;
  localparam int SCALE_W    = TIMER_BITS + MS_W;
  localparam int CMP_W      = (PROD_W > SCALE_W) ? PROD_W : SCALE_W;

  localparam logic [MS_W-1:0]   MS_PER_S   = 10'd1000;
  localparam logic [RATE_W-1:0] RATE_RESET = 20'd1000;

  localparam logic [TRIG_W-1:0] FIRE_PULL    = 8'd32;
  localparam logic [TRIG_W-1:0] FIRE_RELEASE = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_REG_EFFECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_RATE   = 1'b1;

  localparam logic [EFF_W-1:0] EFF_PASS  = 3'd0;
  localparam logic [EFF_W-1:0] EFF_FLAT  = 3'd1;
  localparam logic [EFF_W-1:0] EFF_GUN   = 3'd2;
  localparam logic [EFF_W-1:0] EFF_HEART = 3'd3;
  localparam logic [EFF_W-1:0] EFF_FOOT  = 3'd4;

  localparam logic [PHASE_W-1:0] PH_WAIT_RELEASE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_PULL    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PLAY         = 2'd2;

  localparam logic [STEP_W-1:0] GUN_STEP_FULL  = 3'd2;
  localparam logic [STEP_W-1:0] GUN_STEP_REARM = 3'd3;

  localparam logic [LVL_W-1:0] LVL_ZERO  = 8'd0;
  localparam logic [LVL_W-1:0] LVL_FULL  = 8'd255;
  localparam logic [LVL_W-1:0] LVL_0P8   = 8'd204;
  localparam logic [LVL_W-1:0] LVL_0P3   = 8'd77;
  localparam logic [LVL_W-1:0] LVL_0P2   = 8'd51;
  localparam logic [LVL_W-1:0] LVL_0P02  = 8'd5;

  typedef enum logic [2:0] {
    TRK_FLAT_L,
    TRK_GUN_L,
    TRK_HEART_L,
    TRK_HEART_R,
    TRK_FOOT_L,
    TRK_FOOT_R
  } track_t;

  typedef struct packed {
    logic [STEP_W-1:0]     step;
    logic [TIMER_BITS-1:0] elapsed;
  } seg_t;

  function automatic logic [STEP_W-1:0] trk_len(track_t t);
    case (t)
      TRK_FLAT_L:  return 3'd3;
      TRK_GUN_L:   return 3'd4;
      TRK_HEART_L: return 3'd5;
      TRK_HEART_R: return 3'd5;
      TRK_FOOT_L:  return 3'd4;
      TRK_FOOT_R:  return 3'd4;
      default:     return 3'd1;
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] trk_dur(track_t t, logic [STEP_W-1:0] s);
    case (t)
      TRK_FLAT_L: begin
        case (s)
          3'd0:    return 14'd33;
          3'd1:    return 14'd80;
          default: return 14'd16;
        endcase
      end
      TRK_GUN_L: begin
        case (s)
          3'd0:    return 14'd20;
          3'd1:    return 14'd10;
          3'd2:    return 14'd90;
          default: return 14'd10000;
        endcase
      end
      TRK_HEART_L, TRK_HEART_R: begin
        case (s)
          3'd0:    return 14'd25;
          3'd1:    return 14'd200;
          3'd2:    return 14'd25;
          3'd3:    return 14'd10;
          default: return 14'd745;
        endcase
      end
      default: begin
        case (s)
          3'd0:    return 14'd25;
          3'd1:    return 14'd600;
          3'd2:    return 14'd25;
          default: return 14'd600;
        endcase
      end
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] trk_lvl(track_t t, logic [STEP_W-1:0] s);
    case (t)
      TRK_FLAT_L:  return (s == 3'd0) ? LVL_0P8 : LVL_ZERO;
      TRK_GUN_L:   return (s == 3'd0) ? LVL_FULL : LVL_ZERO;
      TRK_HEART_L: return (s == 3'd0) ? LVL_0P2 : LVL_ZERO;
      TRK_HEART_R: begin
        case (s)
          3'd2:    return LVL_0P2;
          3'd3:    return LVL_0P02;
          default: return LVL_ZERO;
        endcase
      end
      TRK_FOOT_L:  return (s == 3'd0) ? LVL_0P3 : LVL_ZERO;
      TRK_FOOT_R:  return (s == 3'd2) ? LVL_0P3 : LVL_ZERO;
      default:     return LVL_ZERO;
    endcase
  endfunction

endpackage

// ===== sv/haptic_effect_envelope_sequencer.sv =====
// Top level of the haptic effect envelope sequencer.
//
// Usage:
//   Each input word is one timer tick with the two trigger positions. Each
//   accepted word gives exactly one output word with the four drive levels
//   (left and right motor, left and right trigger actuator) after that tick.
//   Configuration words on the cfg channel select the effect (index 0) or set
//   the tick rate in Hz (index 1); write them only while the block is idle.
//   Writing the effect clears every step, timer, gun phase and held drive.
//   Path: an accepted word goes through the input register, then the output
//   register. Throughput: one word per cycle while out_ready is high, set by
//   the single pass of segment timing (one 20x14 multiply and compare per
//   side) between the input register and the output register.
//   When the receiver stalls, the output word holds and one more input word
//   is taken into the input register; in_ready then falls until out_ready.
//   cfg_ready is always high.
//   Reset selects pass-through, sets the rate to 1000 Hz, clears all state
//   and empties both registers.
module haptic_effect_envelope_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hees_pkg::TRIG_W-1:0]         left_trigger,
  input  logic [hees_pkg::TRIG_W-1:0]         right_trigger,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hees_pkg::LVL_W-1:0]          left_motor,
  output logic [hees_pkg::LVL_W-1:0]          right_motor,
  output logic [hees_pkg::LVL_W-1:0]          left_trigger_drive,
  output logic [hees_pkg::LVL_W-1:0]          right_trigger_drive,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hees_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hees_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [hees_pkg::EFF_W-1:0]       effect;
  logic [hees_pkg::RATE_W-1:0]      rate;
  logic                             s1_valid;
  logic [hees_pkg::TRIG_W-1:0]      s1_lt;
  logic [hees_pkg::TRIG_W-1:0]      s1_rt;
  logic [hees_pkg::STEP_W-1:0]      lstep, lstep_next;
  logic [hees_pkg::STEP_W-1:0]      rstep, rstep_next;
  logic [hees_pkg::TIMER_BITS-1:0]  lel, lel_next;
  logic [hees_pkg::TIMER_BITS-1:0]  rel, rel_next;
  logic [hees_pkg::PHASE_W-1:0]     phase, phase_next;
  logic [hees_pkg::LVL_W-1:0]       lm_next, rm_next, ltd_next, rtd_next;
  logic                             advance;
  hees_pkg::track_t                 trk_l, trk_r;
  hees_pkg::seg_t                   seg_l, seg_r;
  logic [hees_pkg::STEP_W-1:0]      gun_s;

  function automatic logic [hees_pkg::STEP_W-1:0] safe_step(
    hees_pkg::track_t t, logic [hees_pkg::STEP_W-1:0] s);
    return (s < hees_pkg::trk_len(t)) ? s : '0;
  endfunction

  function automatic hees_pkg::seg_t seg_next(
    hees_pkg::track_t t, logic [hees_pkg::STEP_W-1:0] step,
    logic [hees_pkg::TIMER_BITS-1:0] el, logic [hees_pkg::RATE_W-1:0] r);
    logic [hees_pkg::STEP_W-1:0]     s;
    logic [hees_pkg::TIMER_BITS-1:0] e;
    logic [hees_pkg::CMP_W-1:0]      scaled;
    logic [hees_pkg::CMP_W-1:0]      limit;
    hees_pkg::seg_t                  res;
    s = safe_step(t, step);
    e = (el != '1) ? el + hees_pkg::TIMER_BITS'(1) : el;
    // elapsed > floor(rate*ms/1000) exactly when 1000*elapsed > rate*ms
    scaled = hees_pkg::CMP_W'(e) * hees_pkg::CMP_W'(hees_pkg::MS_PER_S);
    limit  = hees_pkg::CMP_W'(r) * hees_pkg::CMP_W'(hees_pkg::trk_dur(t, s));
    if (scaled > limit) begin
      s = ((s + hees_pkg::STEP_W'(1)) >= hees_pkg::trk_len(t)) ? '0
          : s + hees_pkg::STEP_W'(1);
      e = '0;
    end
    res.step    = s;
    res.elapsed = e;
    return res;
  endfunction

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    case (effect)
      hees_pkg::EFF_FLAT:  trk_l = hees_pkg::TRK_FLAT_L;
      hees_pkg::EFF_GUN:   trk_l = hees_pkg::TRK_GUN_L;
      hees_pkg::EFF_HEART: trk_l = hees_pkg::TRK_HEART_L;
      default:             trk_l = hees_pkg::TRK_FOOT_L;
    endcase
    trk_r = (effect == hees_pkg::EFF_HEART) ? hees_pkg::TRK_HEART_R : hees_pkg::TRK_FOOT_R;
  end

  assign seg_l = seg_next(trk_l, lstep, lel, rate);
  assign seg_r = seg_next(trk_r, rstep, rel, rate);
  assign gun_s = safe_step(hees_pkg::TRK_GUN_L, lstep);

  always_comb begin
    lstep_next = lstep;
    rstep_next = rstep;
    lel_next   = lel;
    rel_next   = rel;
    phase_next = phase;
    lm_next    = left_motor;
    rm_next    = right_motor;
    ltd_next   = left_trigger_drive;
    rtd_next   = right_trigger_drive;
    case (effect)
      hees_pkg::EFF_PASS: begin
        lm_next  = s1_lt;
        rm_next  = s1_rt;
        ltd_next = s1_lt;
        rtd_next = s1_rt;
      end
      hees_pkg::EFF_FLAT: begin
        ltd_next   = hees_pkg::trk_lvl(trk_l, safe_step(trk_l, lstep));
        lstep_next = seg_l.step;
        lel_next   = seg_l.elapsed;
      end
      hees_pkg::EFF_GUN: begin
        case (phase)
          hees_pkg::PH_WAIT_PULL: begin
            if (s1_lt >= hees_pkg::FIRE_PULL) begin
              lel_next   = '0;
              phase_next = hees_pkg::PH_PLAY;
            end
          end
          hees_pkg::PH_PLAY: begin
            ltd_next = hees_pkg::trk_lvl(hees_pkg::TRK_GUN_L, gun_s);
            lm_next  = (gun_s == hees_pkg::GUN_STEP_FULL) ? hees_pkg::LVL_FULL
                       : hees_pkg::LVL_ZERO;
            rm_next  = lm_next;
            if (gun_s == hees_pkg::GUN_STEP_REARM) begin
              lstep_next = '0;
              phase_next = hees_pkg::PH_WAIT_RELEASE;
            end else begin
              lstep_next = seg_l.step;
              lel_next   = seg_l.elapsed;
            end
          end
          default: begin
            phase_next = (s1_lt <= hees_pkg::FIRE_RELEASE) ? hees_pkg::PH_WAIT_PULL
                         : hees_pkg::PH_WAIT_RELEASE;
          end
        endcase
      end
      hees_pkg::EFF_HEART, hees_pkg::EFF_FOOT: begin
        ltd_next   = hees_pkg::trk_lvl(trk_l, safe_step(trk_l, lstep));
        rtd_next   = hees_pkg::trk_lvl(trk_r, safe_step(trk_r, rstep));
        lstep_next = seg_l.step;
        lel_next   = seg_l.elapsed;
        rstep_next = seg_r.step;
        rel_next   = seg_r.elapsed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect              <= hees_pkg::EFF_PASS;
      rate                <= hees_pkg::RATE_RESET;
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      lstep               <= '0;
      rstep               <= '0;
      lel                 <= '0;
      rel                 <= '0;
      phase               <= hees_pkg::PH_WAIT_RELEASE;
      left_motor          <= '0;
      right_motor         <= '0;
      left_trigger_drive  <= '0;
      right_trigger_drive <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_lt    <= left_trigger;
        s1_rt    <= right_trigger;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready && cfg_index == hees_pkg::CFG_REG_EFFECT) begin
        effect              <= cfg_data[hees_pkg::EFF_W-1:0];
        lstep               <= '0;
        rstep               <= '0;
        lel                 <= '0;
        rel                 <= '0;
        phase               <= hees_pkg::PH_WAIT_RELEASE;
        left_motor          <= '0;
        right_motor         <= '0;
        left_trigger_drive  <= '0;
        right_trigger_drive <= '0;
      end else if (advance) begin
        lstep               <= lstep_next;
        rstep               <= rstep_next;
        lel                 <= lel_next;
        rel                 <= rel_next;
        phase               <= phase_next;
        left_motor          <= lm_next;
        right_motor         <= rm_next;
        left_trigger_drive  <= ltd_next;
        right_trigger_drive <= rtd_next;
      end
      if (cfg_valid && cfg_ready && cfg_index == hees_pkg::CFG_REG_RATE) begin
        rate <= cfg_data[hees_pkg::RATE_W-1:0];
      end
    end
  end

endmodule

// ===== sv/hees_checker.sv =====
// Port-level checker for the haptic effect envelope sequencer, with its bind.
`include "assert_macros.svh"

module hees_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hees_pkg::LVL_W-1:0]  left_motor,
  input logic [hees_pkg::LVL_W-1:0]  right_motor,
  input logic [hees_pkg::LVL_W-1:0]  left_trigger_drive,
  input logic [hees_pkg::LVL_W-1:0]  right_trigger_drive
);

  `HEES_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output word dropped while stalled")
  `HEES_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(left_motor) && $stable(right_motor) && $stable(left_trigger_drive) && $stable(right_trigger_drive), "output word changed while stalled")
  `HEES_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `HEES_ASSERT(a_no_stall_in, out_ready |-> in_ready, "input stalled while output drains")
  `HEES_ASSERT(a_out_from_in, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "output word without an input word two cycles before")

endmodule

bind haptic_effect_envelope_sequencer hees_checker u_hees_checker (.*);
